@@ src/slrp_pkg.sv @@
// Shared types, constants and the header table for the server list reply parser.
package slrp_pkg;

   // Width of the running entry counter inside the parser.
   localparam int COUNT_WIDTH = 16;

   // Reply header: four signature bytes followed by the command text.
   localparam int HEADER_LEN   = 22;
   localparam int HEADER_POS_W = 5;

   localparam logic [7:0]  RECORD_MARK = 8'h5C;        // backslash
   localparam logic [31:0] EOT_MARK    = 32'h454F5400; // "EOT" then a zero byte
   localparam logic [15:0] COUNT_OUT_MAX = 16'hFFFF;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_RECORDS = 2'd1,
      PH_DONE    = 2'd2,
      PH_REJECT  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ENTRY    = 2'd0,
      KIND_ACCEPTED = 2'd1,
      KIND_REJECTED = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] server_ip;
      logic [15:0] server_port;
      logic [15:0] entry_count;
      logic        last;
   } result_type;

   // Results produced by one byte: up to two, the entry (if any) in slot zero.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] header_byte(input logic [HEADER_POS_W-1:0] pos);
      logic [7:0] value;
      case (pos)
         5'd0, 5'd1, 5'd2, 5'd3: value = 8'hFF;
         5'd4:  value = "g";
         5'd5:  value = "e";
         5'd6:  value = "t";
         5'd7:  value = "s";
         5'd8:  value = "e";
         5'd9:  value = "r";
         5'd10: value = "v";
         5'd11: value = "e";
         5'd12: value = "r";
         5'd13: value = "s";
         5'd14: value = "R";
         5'd15: value = "e";
         5'd16: value = "s";
         5'd17: value = "p";
         5'd18: value = "o";
         5'd19: value = "n";
         5'd20: value = "s";
         5'd21: value = "e";
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

@@ src/slrp_parser.sv @@
// Input register and per-byte parsing state of the server list reply parser.
module slrp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        in_byte,
   input  logic              in_end,
   output logic              busy,
   output slrp_pkg::push_type push
);
   import slrp_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    in_end_ff;

   phase_type               phase_ff, phase_in;
   logic [HEADER_POS_W-1:0] header_pos_ff, header_pos_in;
   logic [2:0]              record_pos_ff, record_pos_in;
   logic [31:0]             address_ff, address_in;
   logic [7:0]              port_high_ff, port_high_in;
   logic [COUNT_WIDTH-1:0]  entries_ff, entries_in;

   logic [31:0]             address_next;
   logic                    entry_made;
   logic [31:0]             entries_wide;
   result_type              entry_res;
   result_type              final_res;

   assign in_valid_in  = in_accept;
   assign busy         = in_valid_ff;
   assign address_next = {address_ff[23:0], in_byte_ff};

   always_comb begin
      phase_in      = phase_ff;
      header_pos_in = header_pos_ff;
      record_pos_in = record_pos_ff;
      address_in    = address_ff;
      port_high_in  = port_high_ff;
      entries_in    = entries_ff;
      entry_made    = 1'b0;

      if (in_valid_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               if (in_byte_ff == header_byte(header_pos_ff)) begin
                  header_pos_in = header_pos_ff + 1'b1;
                  if (header_pos_ff == HEADER_POS_W'(HEADER_LEN - 1)) begin
                     phase_in      = PH_RECORDS;
                     record_pos_in = 3'd0;
                  end
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_RECORDS: begin
               case (record_pos_ff)
                  3'd0: begin
                     if (in_byte_ff == RECORD_MARK) begin
                        record_pos_in = 3'd1;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  3'd1, 3'd2, 3'd3, 3'd4: begin
                     address_in    = address_next;
                     record_pos_in = record_pos_ff + 3'd1;
                     if (record_pos_ff == 3'd4 && address_next == EOT_MARK) begin
                        phase_in = PH_DONE;
                     end
                  end
                  3'd5: begin
                     port_high_in  = in_byte_ff;
                     record_pos_in = 3'd6;
                  end
                  default: begin
                     entry_made = 1'b1;
                     if (entries_ff != {COUNT_WIDTH{1'b1}}) begin
                        entries_in = entries_ff + 1'b1;
                     end
                     record_pos_in = 3'd0;
                     address_in    = '0;
                     port_high_in  = '0;
                  end
               endcase
            end
            default: ;
         endcase
      end

      // The result for the final byte is taken from the updated state above.
      entries_wide = 32'(entries_in);
      final_res.server_ip   = '0;
      final_res.server_port = '0;
      final_res.last        = 1'b1;
      if (phase_in == PH_RECORDS || phase_in == PH_DONE) begin
         final_res.kind        = KIND_ACCEPTED;
         final_res.entry_count = (entries_wide > 32'(COUNT_OUT_MAX)) ?
                                 COUNT_OUT_MAX : entries_wide[15:0];
      end else begin
         final_res.kind        = KIND_REJECTED;
         final_res.entry_count = '0;
      end

      entry_res.kind        = KIND_ENTRY;
      entry_res.server_ip   = address_ff;
      entry_res.server_port = {port_high_ff, in_byte_ff};
      entry_res.entry_count = '0;
      entry_res.last        = ~in_end_ff;

      push.count  = 2'd0;
      push.first  = final_res;
      push.second = final_res;
      if (in_valid_ff) begin
         if (entry_made) begin
            push.first = entry_res;
            push.count = in_end_ff ? 2'd2 : 2'd1;
         end else if (in_end_ff) begin
            push.count = 2'd1;
         end
      end

      // Every datagram ends by returning to the reset state.
      if (in_valid_ff && in_end_ff) begin
         phase_in      = PH_HEADER;
         header_pos_in = '0;
         record_pos_in = '0;
         address_in    = '0;
         port_high_in  = '0;
         entries_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_HEADER;
         header_pos_ff <= '0;
         record_pos_ff <= '0;
         address_ff    <= '0;
         port_high_ff  <= '0;
         entries_ff    <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         phase_ff      <= phase_in;
         header_pos_ff <= header_pos_in;
         record_pos_ff <= record_pos_in;
         address_ff    <= address_in;
         port_high_ff  <= port_high_in;
         entries_ff    <= entries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_byte_ff <= in_byte;
         in_end_ff  <= in_end;
      end
   end

endmodule

@@ src/slrp_result_fifo.sv @@
// Small result queue that takes up to two results a cycle and gives one.
module slrp_result_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  slrp_pkg::push_type            push,
   input  logic                          pop,
   output logic                          out_valid,
   output slrp_pkg::result_type          out_data,
   output logic [slrp_pkg::FIFO_CNT_W-1:0] level
);
   import slrp_pkg::*;

   result_type              store_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   level_ff, level_in;
   logic                    do_pop;

   assign out_valid = (level_ff != '0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(do_pop);
      level_in  = level_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         store_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         store_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= push.second;
      end
   end

endmodule

@@ src/server_list_reply_parser_unit.sv @@
// Top level of the server list reply parser: stream ports, parser and result queue.
//
// The req_ channel carries one byte of a master-server reply datagram per
// transaction, with req_tlast set on the datagram's final byte. The parser
// checks the four 0xFF signature bytes and the "getserversResponse" text, then
// reads seven-byte records (backslash, four address bytes, big-endian port).
// The rsp_ channel carries one result per transaction: a server entry for each
// complete record, and on the final byte an accepted result with the entry
// count or a rejected result. rsp_tlast marks the last result that a byte
// caused; a final byte that also completes a record gives two results.
// An accepted byte is registered in the input register, and its results are
// then written to the result queue, from which the rsp_ ports are driven.
// The unit takes one byte per cycle while req_tready is high; a byte that yields
// two results outpaces the output, and the eight-entry result queue absorbs the excess.
// When the receiver stalls, results collect in the queue and req_tready falls
// once too little room is left for the byte in flight and one more.
// A synchronous reset empties the queue and returns the parser to the header
// phase, ready for the first byte of a new datagram.
module server_list_reply_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // end_of_datagram
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] server_ip, [47:32] server_port,
                                    // [63:48] entry_count
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);
   import slrp_pkg::*;

   // Room check: the byte in the input register may still add two results,
   // and a byte accepted now may add two more once it is in that register.
   localparam int SUM_W = FIFO_CNT_W + 1;
   localparam logic [SUM_W-1:0] READY_LIMIT = SUM_W'(FIFO_DEPTH - 2);

   logic                  busy;
   logic                  req_accept;
   push_type              push;
   result_type            head;
   logic [FIFO_CNT_W-1:0] level;
   logic [SUM_W-1:0]      committed;

   assign committed  = SUM_W'(level) + (busy ? SUM_W'(2) : SUM_W'(0));
   assign req_tready = (committed <= READY_LIMIT);
   assign req_accept = req_tvalid && req_tready;

   slrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_tdata),
      .in_end    (req_tlast),
      .busy      (busy),
      .push      (push)
   );

   slrp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (head),
      .level     (level)
   );

   // Unused fields are already zero in each result, so packing is direct.
   assign rsp_tdata = {head.entry_count, head.server_port, head.server_ip};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

@@ tb/slrp_board_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard class for the server list reply parser: byte-level predictor and result checker.
package slrp_board_pkg;

   import slrp_pkg::*;

   localparam int    SIGNATURE_LEN = 4;
   localparam string REPLY_COMMAND = "getserversResponse";

   class reply_scoreboard;
      phase_type               phase;
      logic [HEADER_POS_W-1:0] header_pos;
      logic [2:0]              record_pos;
      logic [31:0]             address_shift;
      logic [7:0]              port_high;
      logic [COUNT_WIDTH-1:0]  entries_seen;
      result_type              awaited[$];
      int unsigned             errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         phase         = PH_HEADER;
         header_pos    = '0;
         record_pos    = '0;
         address_shift = '0;
         port_high     = '0;
         entries_seen  = '0;
      endfunction

      // Byte expected at a given position of the reply header.
      static function logic [7:0] signature_byte(int pos);
         if (pos < SIGNATURE_LEN) begin
            return 8'hFF;
         end
         return REPLY_COMMAND[pos - SIGNATURE_LEN];
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Advances the predicted parser by one accepted byte and queues its results.
      function void note_byte(logic [7:0] value, logic closing);
         result_type outcome;
         if (phase == PH_HEADER) begin
            if (header_pos < HEADER_LEN && value == signature_byte(header_pos)) begin
               header_pos++;
               if (header_pos == HEADER_LEN) begin
                  phase      = PH_RECORDS;
                  record_pos = '0;
               end
            end else begin
               phase = PH_REJECT;
            end
         end else if (phase == PH_RECORDS) begin
            if (record_pos == 0) begin
               if (value == RECORD_MARK) begin
                  record_pos = 1;
               end else begin
                  phase = PH_DONE;
               end
            end else if (record_pos <= 4) begin
               address_shift = {address_shift[23:0], value};
               record_pos++;
               if (record_pos == 5 && address_shift == EOT_MARK) begin
                  phase = PH_DONE;
               end
            end else if (record_pos == 5) begin
               port_high  = value;
               record_pos = 6;
            end else begin
               if (entries_seen != '1) begin
                  entries_seen++;
               end
               outcome             = '0;
               outcome.kind        = KIND_ENTRY;
               outcome.server_ip   = address_shift;
               outcome.server_port = {port_high, value};
               outcome.last        = !closing;
               awaited.push_back(outcome);
               record_pos    = '0;
               address_shift = '0;
               port_high     = '0;
            end
         end

         if (closing) begin
            outcome      = '0;
            outcome.last = 1'b1;
            if (phase == PH_RECORDS || phase == PH_DONE) begin
               outcome.kind        = KIND_ACCEPTED;
               outcome.entry_count = (entries_seen > COUNT_OUT_MAX) ?
                                     COUNT_OUT_MAX : 16'(entries_seen);
            end else begin
               outcome.kind = KIND_REJECTED;
            end
            awaited.push_back(outcome);
            restart();
         end
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] seen);
         errors++;
         $display("%0t: %s expected %h, got %h", $time, field, want, seen);
      endfunction

      // Compares one result transaction with the oldest prediction.
      function void check_result(result_type seen);
         result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got kind %0d ip %h port %h",
                     $time, seen.kind, seen.server_ip, seen.server_port);
            return;
         end
         want = awaited.pop_front();
         if (seen.kind !== want.kind) report("kind", want.kind, seen.kind);
         if (seen.server_ip !== want.server_ip)
            report("server_ip", want.server_ip, seen.server_ip);
         if (seen.server_port !== want.server_port)
            report("server_port", want.server_port, seen.server_port);
         if (seen.entry_count !== want.entry_count)
            report("entry_count", want.entry_count, seen.entry_count);
         if (seen.last !== want.last) report("last", want.last, seen.last);
      endfunction
   endclass

endpackage

@@ tb/tb_server_list_reply_parser_unit.sv @@
`timescale 1ns / 1ps
// Testbench for the server list reply parser: streams reply datagrams and checks every result.
module tb_server_list_reply_parser_unit;

   import slrp_pkg::*;
   import slrp_board_pkg::*;

   // Well above the run with the longest gaps and stalls on every transaction.
   localparam longint RUN_LIMIT_NS = 64'd8_000_000;
   localparam int     RANDOM_BYTES = 1000;
   localparam int     LONG_HOLD    = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Handshake shaping, set by the stimulus and read by the driving processes.
   bit tx_idling    = 1'b0;
   bit rsp_idling   = 1'b0;
   bit hold_request = 1'b0;
   int items_sent   = 0;

   // Bytes of the datagram being assembled; the final one goes out with req_tlast.
   logic [7:0] frame_bytes[$];

   reply_scoreboard board = new();

   server_list_reply_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_header(int upto);
      for (int pos = 0; pos < upto; pos++) begin
         frame_bytes.push_back(reply_scoreboard::signature_byte(pos));
      end
   endfunction

   function automatic void push_record(logic [31:0] address, logic [15:0] port);
      frame_bytes.push_back(RECORD_MARK);
      for (int i = 3; i >= 0; i--) begin
         frame_bytes.push_back(address[8*i +: 8]);
      end
      frame_bytes.push_back(port[15:8]);
      frame_bytes.push_back(port[7:0]);
   endfunction

   function automatic void push_junk(int count);
      repeat (count) frame_bytes.push_back(8'($urandom));
   endfunction

   // Offers one byte and returns once the transaction has been accepted. During a gap the
   // data lines carry rubbish so that the parser is seen to ignore them.
   task automatic send_byte(input logic [7:0] value, input logic closing);
      int gap;
      gap = tx_idling ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= closing;
      do @(posedge clock); while (!req_tready);
      board.note_byte(value, closing);
      items_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frame_bytes.delete();
   endtask

   // Stops offering bytes and waits until every predicted result has been seen.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // One datagram of the random part. Most are well formed with random records and one of
   // the ways a record list can end; the rest have a damaged or short header, or are noise.
   task automatic random_datagram();
      int style;
      int records;
      int spot;
      logic [7:0] stray;
      style   = $urandom_range(0, 99);
      records = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4) : $urandom_range(5, 14);
      if (style < 75) begin
         push_header(HEADER_LEN);
         repeat (records) push_record($urandom, 16'($urandom));
         case ($urandom_range(0, 4))
            0: ;                                   // ends on the last complete record
            1: begin                               // truncated record
               frame_bytes.push_back(RECORD_MARK);
               push_junk($urandom_range(0, 5));
            end
            2: begin                               // record without its backslash
               stray = 8'($urandom);
               if (stray == RECORD_MARK) stray = 8'h00;
               frame_bytes.push_back(stray);
               if ($urandom_range(0, 1)) push_record($urandom, 16'($urandom));
               push_junk($urandom_range(0, 8));
            end
            3: begin                               // end marker, then trailing bytes
               push_record(EOT_MARK, 16'($urandom));
               push_junk($urandom_range(0, 10));
            end
            default: begin                         // address one bit away from the marker
               push_record(EOT_MARK ^ (32'd1 << $urandom_range(0, 31)), 16'($urandom));
            end
         endcase
      end else if (style < 85) begin
         push_header(HEADER_LEN);
         spot = $urandom_range(0, HEADER_LEN - 1);
         frame_bytes[spot] = frame_bytes[spot] ^ 8'($urandom_range(1, 255));
         repeat (records) push_record($urandom, 16'($urandom));
      end else if (style < 93) begin
         push_header($urandom_range(1, HEADER_LEN - 1));
      end else begin
         push_junk($urandom_range(1, 30));
      end
      send_frame();
   endtask

   // Receiver: takes result transactions, with random stalls when asked and one long hold.
   initial begin
      int         stall_left;
      int         gap;
      result_type seen;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            seen.kind        = kind_type'(rsp_tuser);
            seen.server_ip   = rsp_tdata[31:0];
            seen.server_port = rsp_tdata[47:32];
            seen.entry_count = rsp_tdata[63:48];
            seen.last        = rsp_tlast;
            board.check_result(seen);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
            rsp_tready  <= 1'b0;
         end else if (!rsp_idling) begin
            rsp_tready <= 1'b1;
         end else begin
            gap = gap_length();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               stall_left = gap - 1;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // Stimulus.
   initial begin
      int random_start;
      int datagram_index;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed datagrams: the header alone is accepted with no entries.
      push_header(HEADER_LEN);
      send_frame();
      // A lone signature byte, and a header one byte short, are both rejected.
      frame_bytes.push_back(8'hFF);
      send_frame();
      push_header(HEADER_LEN - 1);
      send_frame();
      // A wrong header byte rejects the datagram and the bytes behind it are ignored.
      push_header(10);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(RECORD_MARK);
      push_junk(3);
      send_frame();
      // Extreme addresses and ports; the final byte completes a record, so two results.
      push_header(HEADER_LEN);
      push_record(32'hFFFF_FFFF, 16'hFFFF);
      push_record(32'h0000_0000, 16'h0000);
      send_frame();
      // A record without its backslash stops parsing; the record after it is ignored.
      push_header(HEADER_LEN);
      push_record(32'hC0A8_0001, 16'd27960);
      frame_bytes.push_back(8'h00);
      push_record(32'h0A00_0001, 16'd27961);
      send_frame();
      // The end marker stops parsing and yields no entry.
      push_header(HEADER_LEN);
      push_record(EOT_MARK, 16'h1234);
      push_record(32'h0102_0304, 16'h0506);
      send_frame();
      // An address close to the end marker is an ordinary entry; the trailing record is
      // cut short and counts for nothing.
      push_header(HEADER_LEN);
      push_record(EOT_MARK | 32'h1, 16'h0001);
      frame_bytes.push_back(RECORD_MARK);
      frame_bytes.push_back(8'h0A);
      frame_bytes.push_back(8'h00);
      send_frame();
      wait_for_results();

      // Random datagrams with changing handshake shapes.
      random_start   = items_sent;
      datagram_index = 0;
      while (items_sent - random_start < RANDOM_BYTES) begin
         tx_idling  = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         if (datagram_index == 6) begin
            // Receiver holds off while a long reply streams in, so the result queue fills.
            hold_request = 1'b1;
            push_header(HEADER_LEN);
            repeat (20) push_record($urandom, 16'($urandom));
            send_frame();
         end else begin
            if (datagram_index == 12) wait_for_results();
            random_datagram();
         end
         datagram_index++;
      end

      wait_for_results();
      repeat (16) @(posedge clock);
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
src/slrp_pkg.sv
src/slrp_parser.sv
src/slrp_result_fifo.sv
src/server_list_reply_parser_unit.sv
tb/slrp_board_pkg.sv
tb/tb_server_list_reply_parser_unit.sv
